// ----- rtl/bba_pkg.sv -----
// ============================================================================
// bba_pkg
// Shared types, codes and default sizes for the buddy block allocator.
// ============================================================================
package bba_pkg;

    localparam int BBA_HEAP_BYTES   = 16384;
    localparam int BBA_LEVELS       = 10;
    localparam int BBA_HEADER_BYTES = 16;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_ALLOCATED = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_FREED     = 2'd2,
        STAT_BAD_FREE  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SCAN_RD,
        S_A_SCAN_CHK,
        S_A_SPLIT_RD,
        S_A_SPLIT_WR,
        S_A_MARK_RD,
        S_A_MARK_WR,
        S_F_LOOK_RD,
        S_F_LOOK_CHK,
        S_F_FREE_RD,
        S_F_FREE_WR,
        S_F_BUD_RD,
        S_F_BUD_CHK,
        S_F_PAR_RD,
        S_F_PAR_WR
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] req_size;
        logic [13:0] addr;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [13:0] addr_out;
        logic [3:0]  level_out;
        logic [14:0] free_bytes;
    } rsp_t;

endpackage

// ----- rtl/buddy_block_allocator.sv -----
// ============================================================================
// buddy_block_allocator
// Buddy allocator: free/alloc bit trees in row memories, walked by a sequencer.
// ============================================================================
// Allocate: scan rows of the working level, then split down to the fit level;
//   free: probe aligned levels, then merge upward with free buddies;
//   refused requests go straight to the result slot (bad frees after any probing).
// Throughput: one transaction at a time; the row-memory port sets the pace.
// Reset: free/alloc row memories are swept clear, one row per cycle
//   (2^(max(LEVELS,6)-5) rows, 32 at defaults), before the first request.
module buddy_block_allocator
#(
    parameter int HEAP_BYTES   = bba_pkg::BBA_HEAP_BYTES,
    parameter int LEVELS       = bba_pkg::BBA_LEVELS,
    parameter int HEADER_BYTES = bba_pkg::BBA_HEADER_BYTES
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bba_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bba_pkg::rsp_t rsp
);
    import bba_pkg::*;

    localparam int HB_LOG = $clog2(HEAP_BYTES);
    localparam int IW     = (LEVELS > 6) ? LEVELS : 6;
    localparam int RAW    = IW - 5;
    localparam int NROWS  = 1 << RAW;
    localparam int LV_W   = $clog2(LEVELS);
    localparam int CW     = (HB_LOG + 1 > 17) ? HB_LOG + 1 : 17;
    localparam int FT_W   = HB_LOG + 1;
    localparam int CNT_W  = IW + 1;
    localparam logic [LV_W-1:0] LV_TOP = LV_W'(LEVELS - 1);
    localparam logic [CW-1:0]   HEAP_C = CW'(HEAP_BYTES);
    localparam logic [CW-1:0]   HDR_C  = CW'(HEADER_BYTES);
    localparam logic [RAW-1:0]  ROW_LAST = RAW'(NROWS - 1);

    // block bytes at a level
    function automatic logic [CW-1:0] blk(input logic [LV_W-1:0] lv);
        return HEAP_C >> lv;
    endfunction

    // first 1-based node index of a level
    function automatic logic [IW-1:0] lv_first(input logic [LV_W-1:0] lv);
        return IW'(1) << lv;
    endfunction

    // row bits that belong to a level (only row 0 mixes levels)
    function automatic logic [31:0] lvl_mask(input logic [LV_W-1:0] lv);
        logic [31:0] m;
        m = '0;
        for (int b = 0; b < 32; b++)
        begin
            m[b] = (int'(lv) >= 5) || ((32'(b) >> lv) == 32'd1);
        end
        return m;
    endfunction

    // --------------------------------------------------------------------
    // state
    // --------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [CW-1:0]     h_reg, h_next;
    logic [LV_W-1:0]   lv_reg, lv_next;      // target level
    logic [LV_W-1:0]   j_reg, j_next;        // working level
    logic [RAW-1:0]    row_reg, row_next;
    logic [IW-1:0]     idx_reg, idx_next;    // 1-based node index
    logic [FT_W-1:0]   free_total_reg, free_total_next;
    status_t           stat_reg, stat_next;
    logic [13:0]       paddr_reg, paddr_next;
    logic [LV_W-1:0]   plvl_reg, plvl_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;
    logic [CNT_W-1:0]  cnt_reg [LEVELS];

    // row memories
    logic [31:0]       free_mem  [NROWS];
    logic [31:0]       alloc_mem [NROWS];
    logic [31:0]       free_rd_reg, alloc_rd_reg;
    logic [RAW-1:0]    rd_row, wr_row;
    logic              fw_en, aw_en;
    logic [31:0]       fw_data, aw_data;

    // free-count update port
    logic              cnt_en;
    logic [LV_W-1:0]   cnt_idx;
    logic [CNT_W-1:0]  cnt_delta;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // --------------------------------------------------------------------
    // registers
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            row_reg        <= '0;
            free_total_reg <= FT_W'(HEAP_BYTES);
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            free_total_reg <= free_total_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg     <= h_next;
        lv_reg    <= lv_next;
        j_reg     <= j_next;
        idx_reg   <= idx_next;
        stat_reg  <= stat_next;
        paddr_reg <= paddr_next;
        plvl_reg  <= plvl_next;
        rsp_reg   <= rsp_next;
    end

    // per-level free block counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                cnt_reg[i] <= (i == 0) ? CNT_W'(1) : '0;
            end
        end
        else if (cnt_en)
        begin
            cnt_reg[cnt_idx] <= cnt_reg[cnt_idx] + cnt_delta;
        end
    end

    // row memories: one write row, one read row, registered read
    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            free_mem[wr_row] <= fw_data;
        end
        if (aw_en)
        begin
            alloc_mem[wr_row] <= aw_data;
        end
        free_rd_reg  <= free_mem[rd_row];
        alloc_rd_reg <= alloc_mem[rd_row];
    end

    // --------------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------------
    always_comb
    begin
        logic [CW-1:0]   size;
        logic [LV_W-1:0] fit, lvl0, jsel;
        logic            any_free;
        logic [31:0]     m;
        logic [4:0]      pb;
        logic            zb;
        logic [4:0]      sh;
        logic [IW-1:0]   cand;
        logic [IW-1:0]   child;
        logic [CW-1:0]   off;

        state_next      = state_reg;
        h_next          = h_reg;
        lv_next         = lv_reg;
        j_next          = j_reg;
        row_next        = row_reg;
        idx_next        = idx_reg;
        free_total_next = free_total_reg;
        stat_next       = stat_reg;
        paddr_next      = paddr_reg;
        plvl_next       = plvl_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        rd_row          = idx_reg[IW-1:5];
        wr_row          = idx_reg[IW-1:5];
        fw_en           = 1'b0;
        aw_en           = 1'b0;
        fw_data         = free_rd_reg;
        aw_data         = alloc_rd_reg;
        cnt_en          = 1'b0;
        cnt_idx         = j_reg;
        cnt_delta       = CNT_W'(1);

        // request decode: fit level, largest free level, deepest usable level
        size     = CW'(req.req_size) + HDR_C;
        fit      = '0;
        lvl0     = '0;
        jsel     = '0;
        any_free = 1'b0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (cnt_reg[l] != '0)
            begin
                lvl0     = LV_W'(l);
                any_free = 1'b1;
            end
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            if (blk(LV_W'(l)) >= size)
            begin
                fit = LV_W'(l);
            end
        end
        for (int l = 0; l < LEVELS; l++)
        begin
            if ((cnt_reg[l] != '0) && (LV_W'(l) <= fit))
            begin
                jsel = LV_W'(l);
            end
        end

        // level geometry for the working level
        zb   = (int'(j_reg) > HB_LOG);
        sh   = zb ? 5'd0 : 5'(HB_LOG - int'(j_reg));
        cand = lv_first(j_reg) | IW'(h_reg >> sh);

        // lowest free bit of the scanned row at the working level
        m  = free_rd_reg & lvl_mask(j_reg);
        pb = '0;
        for (int b = 31; b >= 0; b--)
        begin
            if (m[b])
            begin
                pb = 5'(b);
            end
        end

        child = IW'({idx_reg, 1'b1});
        off   = (int'(lv_reg) > HB_LOG) ? '0 :
                (CW'(idx_reg ^ lv_first(lv_reg)) << (5'(HB_LOG) - 5'(lv_reg)));

        // result register drains independently
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_row   = row_reg;
                fw_en    = 1'b1;
                aw_en    = 1'b1;
                fw_data  = (row_reg == '0) ? 32'd2 : 32'd0;
                aw_data  = '0;
                row_next = row_reg + RAW'(1);
                if (row_reg == ROW_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    paddr_next = '0;
                    plvl_next  = '0;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (!any_free || size > blk(lvl0))
                        begin
                            stat_next  = STAT_NO_SPACE;
                            state_next = S_A_MARK_WR;
                        end
                        else
                        begin
                            lv_next    = fit;
                            j_next     = jsel;
                            row_next   = RAW'(lv_first(jsel) >> 5);
                            state_next = S_A_SCAN_RD;
                        end
                    end
                    else
                    begin
                        h_next = CW'(req.addr) - HDR_C;
                        j_next = '0;
                        if ((CW'(req.addr) < HDR_C) || (CW'(req.addr) - HDR_C >= HEAP_C))
                        begin
                            stat_next  = STAT_BAD_FREE;
                            state_next = S_A_MARK_WR;
                        end
                        else
                        begin
                            state_next = S_F_LOOK_RD;
                        end
                    end
                end
            end

            // scan rows of the working level for its lowest free node
            S_A_SCAN_RD:
            begin
                rd_row     = row_reg;
                state_next = S_A_SCAN_CHK;
            end

            S_A_SCAN_CHK:
            begin
                if (m != '0)
                begin
                    wr_row    = row_reg;
                    fw_en     = 1'b1;
                    fw_data   = free_rd_reg & ~(32'd1 << pb);
                    cnt_en    = 1'b1;
                    cnt_delta = '1;
                    idx_next  = IW'({row_reg, pb});
                    state_next = (j_reg == lv_reg) ? S_A_MARK_RD : S_A_SPLIT_RD;
                end
                else
                begin
                    row_next   = row_reg + RAW'(1);
                    state_next = S_A_SCAN_RD;
                end
            end

            // split: free the right half, keep the left
            S_A_SPLIT_RD:
            begin
                rd_row     = child[IW-1:5];
                state_next = S_A_SPLIT_WR;
            end

            S_A_SPLIT_WR:
            begin
                wr_row    = child[IW-1:5];
                fw_en     = 1'b1;
                fw_data   = free_rd_reg | (32'd1 << child[4:0]);
                cnt_en    = 1'b1;
                cnt_idx   = j_reg + LV_W'(1);
                idx_next  = IW'({idx_reg, 1'b0});
                j_next    = j_reg + LV_W'(1);
                state_next = ((j_reg + LV_W'(1)) == lv_reg) ? S_A_MARK_RD : S_A_SPLIT_RD;
            end

            S_A_MARK_RD:
            begin
                state_next = S_A_MARK_WR;
                stat_next  = STAT_ALLOCATED;
            end

            // mark allocation; also the result slot for every path but the grant, which goes out from S_F_PAR_RD
            S_A_MARK_WR:
            begin
                if (stat_reg == STAT_ALLOCATED)
                begin
                    aw_en           = 1'b1;
                    aw_data         = alloc_rd_reg | (32'd1 << idx_reg[4:0]);
                    free_total_next = free_total_reg - FT_W'(blk(lv_reg));
                    paddr_next      = 14'(off + HDR_C);
                    plvl_next       = lv_reg;
                    stat_next       = STAT_FREED;   // overridden below by the grant marker
                    state_next      = S_F_PAR_WR;
                    // the grant reuses S_F_PAR_RD, marked by STAT_NO_SPACE
                end
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    if (stat_reg != STAT_ALLOCATED)
                    begin
                        rsp_next.status     = stat_reg;
                        rsp_next.addr_out   = paddr_reg;
                        rsp_next.level_out  = 4'(plvl_reg);
                        rsp_next.free_bytes = 15'(free_total_reg);
                        rsp_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                if (stat_reg == STAT_ALLOCATED)
                begin
                    stat_next  = STAT_ALLOCATED;
                    state_next = S_A_MARK_WR;
                    lv_next    = lv_reg;
                    idx_next   = idx_reg;
                    // hold: S_F_PAR_RD emits the grant
                    stat_next  = STAT_NO_SPACE;
                    state_next = S_F_PAR_RD;
                end
            end

            // free: probe alloc bit of each aligned candidate
            S_F_LOOK_RD:
            begin
                if (zb || ((h_reg & (blk(j_reg) - CW'(1))) != '0))
                begin
                    if (j_reg == LV_TOP)
                    begin
                        stat_next  = STAT_BAD_FREE;
                        state_next = S_A_MARK_WR;
                    end
                    else
                    begin
                        j_next = j_reg + LV_W'(1);
                    end
                end
                else
                begin
                    rd_row     = cand[IW-1:5];
                    state_next = S_F_LOOK_CHK;
                end
            end

            S_F_LOOK_CHK:
            begin
                if (alloc_rd_reg[cand[4:0]])
                begin
                    wr_row     = cand[IW-1:5];
                    aw_en      = 1'b1;
                    aw_data    = alloc_rd_reg & ~(32'd1 << cand[4:0]);
                    idx_next   = cand;
                    plvl_next  = j_reg;
                    state_next = S_F_FREE_RD;
                end
                else if (j_reg == LV_TOP)
                begin
                    stat_next  = STAT_BAD_FREE;
                    state_next = S_A_MARK_WR;
                end
                else
                begin
                    j_next     = j_reg + LV_W'(1);
                    state_next = S_F_LOOK_RD;
                end
            end

            S_F_FREE_RD:
            begin
                state_next = S_F_FREE_WR;
            end

            S_F_FREE_WR:
            begin
                fw_en           = 1'b1;
                fw_data         = free_rd_reg | (32'd1 << idx_reg[4:0]);
                cnt_en          = 1'b1;
                free_total_next = free_total_reg + FT_W'(blk(j_reg));
                stat_next       = STAT_FREED;
                state_next      = (idx_reg == IW'(1)) ? S_A_MARK_WR : S_F_BUD_RD;
            end

            // merge with a free buddy, one level per pass
            S_F_BUD_RD:
            begin
                state_next = S_F_BUD_CHK;
            end

            S_F_BUD_CHK:
            begin
                if (!free_rd_reg[idx_reg[4:0] ^ 5'd1])
                begin
                    state_next = S_A_MARK_WR;
                end
                else
                begin
                    fw_en      = 1'b1;
                    fw_data    = free_rd_reg & ~(32'd3 << {idx_reg[4:1], 1'b0});
                    cnt_en     = 1'b1;
                    cnt_delta  = ~CNT_W'(1);
                    idx_next   = idx_reg >> 1;
                    j_next     = j_reg - LV_W'(1);
                    state_next = S_F_PAR_RD;
                end
            end

            S_F_PAR_RD:
            begin
                if (stat_reg == STAT_NO_SPACE)
                begin
                    // grant waiting for the result slot
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_next.status     = STAT_ALLOCATED;
                        rsp_next.addr_out   = paddr_reg;
                        rsp_next.level_out  = 4'(plvl_reg);
                        rsp_next.free_bytes = 15'(free_total_reg);
                        rsp_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_F_PAR_WR;
                end
            end

            S_F_PAR_WR:
            begin
                fw_en      = 1'b1;
                fw_data    = free_rd_reg | (32'd1 << idx_reg[4:0]);
                cnt_en     = 1'b1;
                state_next = (idx_reg == IW'(1)) ? S_A_MARK_WR : S_F_BUD_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    a_rsp_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_A_MARK_WR ||
                                  $past(state_reg) == S_F_PAR_RD))
        else $error("result raised outside a result state");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_total_reg <= FT_W'(HEAP_BYTES))
        else $error("free byte count above heap size");

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CNT_W'(1))
        else $error("more than one free root");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != S_IDLE)
        else $error("sequencer idle after accepting a request");

endmodule
